// File: hw/rtl/bsmr_pkg.sv
// Shared constants, request and status codes, and controller state type for the stack unit.
package bsmr_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int REQ_W         = 3;
   localparam int STAT_W        = 2;

   localparam logic [REQ_W-1:0] REQ_PUSH    = 3'd0;
   localparam logic [REQ_W-1:0] REQ_POP     = 3'd1;
   localparam logic [REQ_W-1:0] REQ_DISPLAY = 3'd2;
   localparam logic [REQ_W-1:0] REQ_MIDDLE  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_REVERSE = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FEW      = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMIT,
      ST_MEM_EMIT,
      ST_DISP,
      ST_REV_RB,
      ST_REV_WA,
      ST_REV_WB
   } state_type;

endpackage

// File: hw/rtl/bounded_stack_with_middle_and_reverse_unit.sv
// Bounded LIFO stack with display, find-middle and reverse-bottom-half, built on one RAM.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | req_type, req_push_value
//  rsp     | out       | rsp_valid / rsp_ready | rsp_status, rsp_data_value, rsp_last_result
//
// Push, pop, find-middle and error cases pass through ST_EMIT or ST_MEM_EMIT to the output.
// Display emits entries top down; reverse does (count/2)/2 swaps through ST_REV_RB/WA/WB.
// The RAM has a single write port and a single read port with a registered read.
// Reset clears the entry count and the controller; the RAM contents are left as they are.
// A result waits in the output register under rsp back-pressure; the controller holds until it
// drains, and req_ready is high only while the controller is idle.
module bounded_stack_with_middle_and_reverse_unit #(
   parameter int STACK_DEPTH = bsmr_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bsmr_pkg::REQ_W-1:0]        req_type,
   input  logic signed [bsmr_pkg::DATA_W-1:0] req_push_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bsmr_pkg::STAT_W-1:0]       rsp_status,
   output logic signed [bsmr_pkg::DATA_W-1:0] rsp_data_value,
   output logic                              rsp_last_result
);
   import bsmr_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   // stack RAM
   logic [DATA_W-1:0] mem [STACK_DEPTH];
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [DATA_W-1:0] mem_wd;
   logic              mem_re;
   logic [AW-1:0]     mem_ra;
   logic [DATA_W-1:0] rd_data_ff;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [AW-1:0]     hi_ff, hi_in;
   logic [DATA_W-1:0] tmp_ff, tmp_in;
   logic [STAT_W-1:0] res_status_ff, res_status_in;
   logic [DATA_W-1:0] res_data_ff, res_data_in;

   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic              rsp_last_ff;

   logic              out_free;
   logic              out_load;
   logic [STAT_W-1:0] out_status;
   logic [DATA_W-1:0] out_data;
   logic              out_last;

   logic              req_fire;
   logic [CW-1:0]     cnt_m1;
   logic [CW-1:0]     mid_idx;
   logic [CW-1:0]     half;
   logic              is_full;
   logic              is_empty;
   logic [AW:0]       ptr_next2;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign cnt_m1    = count_ff - CW'(1);
   assign mid_idx   = cnt_m1 >> 1;
   assign half      = count_ff >> 1;
   assign is_full   = (count_ff == CW'(STACK_DEPTH));
   assign is_empty  = (count_ff == '0);
   assign ptr_next2 = {1'b0, ptr_ff} + (AW+1)'(2);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      hi_in         = hi_ff;
      tmp_in        = tmp_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      mem_we        = 1'b0;
      mem_wa        = ptr_ff;
      mem_wd        = rd_data_ff;
      mem_re        = 1'b0;
      mem_ra        = ptr_ff;
      out_load      = 1'b0;
      out_status    = STAT_OK;
      out_data      = rd_data_ff;
      out_last      = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_data_in = '0;
               case (req_type)
                  REQ_PUSH: begin
                     state_in = ST_EMIT;
                     if (is_full) begin
                        res_status_in = STAT_OVERFLOW;
                     end else begin
                        mem_we        = 1'b1;
                        mem_wa        = count_ff[AW-1:0];
                        mem_wd        = req_push_value;
                        count_in      = count_ff + CW'(1);
                        res_status_in = STAT_OK;
                        res_data_in   = req_push_value;
                     end
                  end
                  REQ_POP, REQ_MIDDLE: begin
                     if (is_empty) begin
                        res_status_in = STAT_EMPTY;
                        state_in      = ST_EMIT;
                     end else begin
                        mem_re   = 1'b1;
                        mem_ra   = (req_type == REQ_POP) ? cnt_m1[AW-1:0] : mid_idx[AW-1:0];
                        state_in = ST_MEM_EMIT;
                        if (req_type == REQ_POP) begin
                           count_in = cnt_m1;
                        end
                     end
                  end
                  REQ_DISPLAY: begin
                     if (is_empty) begin
                        res_status_in = STAT_EMPTY;
                        state_in      = ST_EMIT;
                     end else begin
                        mem_re   = 1'b1;
                        mem_ra   = cnt_m1[AW-1:0];
                        ptr_in   = cnt_m1[AW-1:0];
                        state_in = ST_DISP;
                     end
                  end
                  REQ_REVERSE: begin
                     if (count_ff < CW'(2)) begin
                        res_status_in = STAT_FEW;
                        state_in      = ST_EMIT;
                     end else if (half < CW'(2)) begin
                        // one entry in the bottom half: nothing to swap
                        res_status_in = STAT_OK;
                        state_in      = ST_EMIT;
                     end else begin
                        res_status_in = STAT_OK;
                        mem_re        = 1'b1;
                        mem_ra        = '0;
                        ptr_in        = '0;
                        hi_in         = AW'(half - CW'(1));
                        state_in      = ST_REV_RB;
                     end
                  end
                  default: begin
                     // drop unknown request codes
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            out_status = res_status_ff;
            out_data   = res_data_ff;
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MEM_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DISP: begin
            out_last = (ptr_ff == '0);
            if (out_free) begin
               out_load = 1'b1;
               if (ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  // fetch the next entry down while this one leaves
                  mem_re = 1'b1;
                  mem_ra = ptr_ff - AW'(1);
                  ptr_in = ptr_ff - AW'(1);
               end
            end
         end
         ST_REV_RB: begin
            tmp_in   = rd_data_ff;
            mem_re   = 1'b1;
            mem_ra   = hi_ff;
            state_in = ST_REV_WA;
         end
         ST_REV_WA: begin
            mem_we   = 1'b1;
            mem_wa   = ptr_ff;
            mem_wd   = rd_data_ff;
            state_in = ST_REV_WB;
         end
         ST_REV_WB: begin
            mem_we = 1'b1;
            mem_wa = hi_ff;
            mem_wd = tmp_ff;
            if (ptr_next2 < {1'b0, hi_ff}) begin
               mem_re   = 1'b1;
               mem_ra   = ptr_ff + AW'(1);
               ptr_in   = ptr_ff + AW'(1);
               hi_in    = hi_ff - AW'(1);
               state_in = ST_REV_RB;
            end else begin
               state_in = ST_EMIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      hi_ff         <= hi_in;
      tmp_ff        <= tmp_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_data_ff   <= out_data;
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_value  = rsp_data_ff;
   assign rsp_last_result = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("entry count beyond stack depth");

   a_known_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_type == REQ_PUSH || req_type == REQ_POP || req_type == REQ_DISPLAY ||
                   req_type == REQ_MIDDLE || req_type == REQ_REVERSE)
      |=> state_ff != ST_IDLE)
      else $error("known request produced no work");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_IDLE || state_ff == ST_REV_WA || state_ff == ST_REV_WB))
      else $error("RAM write outside push or swap");

   a_swap_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REV_RB |-> ptr_ff < hi_ff)
      else $error("swap pointers crossed");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result overwrote a pending transaction");

endmodule

// File: tb/stack_scoreboard.sv
// Scoreboard for the stack unit: mirrors the stack, predicts every response and checks it.
module stack_scoreboard #(
   parameter int STACK_DEPTH = bsmr_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [bsmr_pkg::REQ_W-1:0]         req_type,
   input  logic signed [bsmr_pkg::DATA_W-1:0] req_push_value,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [bsmr_pkg::STAT_W-1:0]        rsp_status,
   input  logic signed [bsmr_pkg::DATA_W-1:0] rsp_data_value,
   input  logic                               rsp_last_result,
   output int                                 mismatch_count,
   output int                                 responses_outstanding
);
   import bsmr_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] data_value;
      logic                     last_result;
   } stack_response_type;

   logic signed [DATA_W-1:0] stack_mirror [STACK_DEPTH];
   int                       mirror_count;
   stack_response_type       awaited_responses [$];
   stack_response_type       oldest;

   initial begin
      mismatch_count = 0;
      responses_outstanding = 0;
      mirror_count = 0;
      for (int i = 0; i < STACK_DEPTH; i++) stack_mirror[i] = '0;
   end

   task automatic await_response(input logic [STAT_W-1:0] status,
                                 input logic signed [DATA_W-1:0] value, input logic last);
      stack_response_type entry;
      entry.status = status;
      entry.data_value = value;
      entry.last_result = last;
      awaited_responses.push_back(entry);
   endtask

   // Apply one request to the mirror and queue the responses it must produce.
   task automatic predict_stack_request(input logic [REQ_W-1:0] kind,
                                        input logic signed [DATA_W-1:0] value);
      int half;
      logic signed [DATA_W-1:0] held;
      case (kind)
         REQ_PUSH: begin
            if (mirror_count >= STACK_DEPTH) begin
               await_response(STAT_OVERFLOW, '0, 1'b1);
            end else begin
               stack_mirror[mirror_count] = value;
               mirror_count++;
               await_response(STAT_OK, value, 1'b1);
            end
         end
         REQ_POP: begin
            if (mirror_count == 0) begin
               await_response(STAT_EMPTY, '0, 1'b1);
            end else begin
               mirror_count--;
               await_response(STAT_OK, stack_mirror[mirror_count], 1'b1);
            end
         end
         REQ_DISPLAY: begin
            if (mirror_count == 0) await_response(STAT_EMPTY, '0, 1'b1);
            for (int i = 0; i < mirror_count; i++)
               await_response(STAT_OK, stack_mirror[mirror_count-1-i], i == mirror_count-1);
         end
         REQ_MIDDLE: begin
            if (mirror_count == 0) await_response(STAT_EMPTY, '0, 1'b1);
            else await_response(STAT_OK, stack_mirror[(mirror_count-1)/2], 1'b1);
         end
         REQ_REVERSE: begin
            if (mirror_count < 2) begin
               await_response(STAT_FEW, '0, 1'b1);
            end else begin
               half = mirror_count / 2;
               for (int i = 0; i < half / 2; i++) begin
                  held = stack_mirror[i];
                  stack_mirror[i] = stack_mirror[half-1-i];
                  stack_mirror[half-1-i] = held;
               end
               await_response(STAT_OK, '0, 1'b1);
            end
         end
         default: ;  // unknown codes are dropped by the block
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mirror_count = 0;
         awaited_responses.delete();
      end else begin
         if (req_valid && req_ready) predict_stack_request(req_type, req_push_value);
         if (rsp_valid && rsp_ready) begin
            if (awaited_responses.size() == 0) begin
               $error("unexpected response: status %0d data_value %0d last_result %0d",
                      rsp_status, rsp_data_value, rsp_last_result);
               mismatch_count++;
            end else begin
               oldest = awaited_responses.pop_front();
               if (rsp_status !== oldest.status) begin
                  $error("status: expected %0d, got %0d", oldest.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_data_value !== oldest.data_value) begin
                  $error("data_value: expected %0d, got %0d",
                         oldest.data_value, rsp_data_value);
                  mismatch_count++;
               end
               if (rsp_last_result !== oldest.last_result) begin
                  $error("last_result: expected %0d, got %0d",
                         oldest.last_result, rsp_last_result);
                  mismatch_count++;
               end
            end
         end
      end
      responses_outstanding = awaited_responses.size();
   end

endmodule

// File: tb/testbench.sv
// Top of the stack unit testbench: clock, reset, request and response traffic, verdict.
module testbench;
   import bsmr_pkg::*;

   localparam int STACK_DEPTH  = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 370;
   localparam int CYCLE_LIMIT  = 900000;
   localparam int SETTLE_CYCLES = 60;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [REQ_W-1:0]         req_type;
   logic signed [DATA_W-1:0] req_push_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0] rsp_data_value;
   logic                     rsp_last_result;

   int          mismatch_count;
   int          responses_outstanding;
   bit          steady_flow;
   int unsigned cycle_count;

   bounded_stack_with_middle_and_reverse_unit #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_type(req_type), .req_push_value(req_push_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_data_value(rsp_data_value),
      .rsp_last_result(rsp_last_result)
   );

   stack_scoreboard #(.STACK_DEPTH(STACK_DEPTH)) scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_type(req_type), .req_push_value(req_push_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_data_value(rsp_data_value),
      .rsp_last_result(rsp_last_result),
      .mismatch_count(mismatch_count),
      .responses_outstanding(responses_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int draw_idle();
      if (steady_flow) return 0;
      if ($urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 19);
   endfunction

   function automatic logic signed [DATA_W-1:0] draw_value();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(0, 15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the transaction with
   // valid still high, so the next call either keeps it up or drops it.
   task automatic send_request(input logic [REQ_W-1:0] kind,
                               input logic signed [DATA_W-1:0] value);
      int idle;
      idle = draw_idle();
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_push_value <= value;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (responses_outstanding != 0) @(negedge clock);
   endtask

   // Response side: stall a random number of cycles, then accept one transaction.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_idle();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      logic [REQ_W-1:0]         kind;
      logic signed [DATA_W-1:0] fill_patterns [4];
      int                       push_pct;
      int                       sent;
      int                       pick;
      fill_patterns[0] = 32'sh55555555;
      fill_patterns[1] = 32'shaaaaaaaa;
      fill_patterns[2] = 32'sh00000000;
      fill_patterns[3] = 32'shffffffff;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_PUSH;
      req_push_value = '0;
      steady_flow = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty-stack errors
      send_request(REQ_POP, 32'sh7fffffff);
      send_request(REQ_DISPLAY, '0);
      send_request(REQ_MIDDLE, '0);
      send_request(REQ_REVERSE, '0);
      // one and two entries, extremes of the value
      send_request(REQ_PUSH, 32'sh7fffffff);
      send_request(REQ_REVERSE, '0);
      send_request(REQ_MIDDLE, '0);
      send_request(REQ_PUSH, 32'sh80000000);
      send_request(REQ_REVERSE, '0);
      send_request(REQ_DISPLAY, '0);
      // unknown codes produce nothing
      send_request(3'd5, 32'sh12345678);
      send_request(3'd6, '0);
      send_request(3'd7, -1);
      // fill to the top, overflow, then work on a full stack
      for (int i = 2; i < STACK_DEPTH; i++)
         send_request(REQ_PUSH, fill_patterns[i % 4] ^ (i << 8));
      send_request(REQ_PUSH, 32'sh0badcafe);
      send_request(REQ_DISPLAY, '0);
      send_request(REQ_REVERSE, '0);
      send_request(REQ_MIDDLE, '0);
      send_request(REQ_DISPLAY, '0);
      send_request(REQ_POP, '0);
      wait_drained();

      // random traffic in segments that alternately grow and shrink the stack
      sent = 0;
      for (int seg = 0; sent < RANDOM_ITEMS; seg++) begin
         steady_flow = (seg % 4 == 2);
         push_pct = (seg % 2 == 0) ? 65 : 25;
         if (seg % 3 == 1) wait_drained();
         for (int k = 0; k < 40 && sent < RANDOM_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               kind = REQ_W'($urandom_range(5, 7));
            end else begin
               sent++;
               if (pick < 3 + push_pct) begin
                  kind = REQ_PUSH;
               end else begin
                  pick = $urandom_range(0, 19);
                  if (pick < 9) kind = REQ_POP;
                  else if (pick < 12) kind = REQ_DISPLAY;
                  else if (pick < 16) kind = REQ_MIDDLE;
                  else kind = REQ_REVERSE;
               end
            end
            send_request(kind, draw_value());
         end
      end
      steady_flow = 1'b0;

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && responses_outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
